// ===== rtl/quota_slot_registry_defines.svh =====
// ----------------------------------------------------------------------------
// quota_slot_registry assertion macros
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef QUOTA_SLOT_REGISTRY_DEFINES_SVH
`define QUOTA_SLOT_REGISTRY_DEFINES_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define QSR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// checked on every edge
`define QSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define QSR_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define QSR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/qsr_pkg.sv =====
// ----------------------------------------------------------------------------
// qsr_pkg
// types, codes and sizes shared by the slot registry
// ----------------------------------------------------------------------------
`default_nettype none

package qsr_pkg;

    localparam int NUM_SLOTS   = 60;
    localparam int NUM_CLASSES = 6;
    localparam int CLASS_LIMIT = 6;

    // classes that can ever be accepted
    localparam int N_CLS = (NUM_CLASSES < CLASS_LIMIT) ? NUM_CLASSES : CLASS_LIMIT;

    localparam int ID_W    = 8;
    localparam int SIDE_W  = 3;
    localparam int STAT_W  = 3;
    localparam int OUT_T_W = 6;
    localparam int COUNT_W = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CLS_W  = (N_CLS > 1) ? $clog2(N_CLS) : 1;
    localparam int TOT_W  = $clog2(NUM_SLOTS + 1);

    localparam logic [TOT_W-1:0]  SLOTS_TOT  = TOT_W'(NUM_SLOTS);
    localparam logic [ID_W-1:0]   SLOTS_ID   = ID_W'(NUM_SLOTS);
    localparam logic [SIDE_W-1:0] CLS_LIMIT  = SIDE_W'(N_CLS);

    localparam logic [COUNT_W-1:0] QUOTA_RESET [CLASS_LIMIT] =
        '{6'd20, 6'd20, 6'd10, 6'd3, 6'd3, 6'd4};

    typedef enum logic [0:0] {
        CMD_REGISTER = 1'b0,
        CMD_QUERY    = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_INIT  = 3'd1,
        ST_BAD_ARG   = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4,
        ST_NOT_REG   = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIMETER_UP     = 3'd0,
        CFG_QUOTA_SOUTH      = 3'd1,
        CFG_QUOTA_NORTH      = 3'd2,
        CFG_QUOTA_WEST       = 3'd3,
        CFG_QUOTA_EAST_LEFT  = 3'd4,
        CFG_QUOTA_EAST_RIGHT = 3'd5,
        CFG_QUOTA_GATE       = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [0:0]        command;
        logic [ID_W-1:0]   slot_id;
        logic [SIDE_W-1:0] side;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [OUT_T_W-1:0] total_count;
        logic               all_active;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/quota_slot_registry.sv =====
// ----------------------------------------------------------------------------
// quota_slot_registry
// slot registry with per-class quotas, register and query commands
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  ---------------------------
//   in       to block   i_in_valid / o_in_stall   command, slot_id, side
//   out      from block o_out_valid / i_out_stall status, total_count, active
//   cfg      to block   i_cfg_valid / o_cfg_ready register index, data
//
// one item per cycle sustained while the output is not stalled; the taken item
// is loaded into the input register, where its slot class is read, and its
// result is then loaded into the result register
// the rate is set by the single read-modify-write of the slot and class
// counters done in the stage behind the input register
// reset clears valid bits and counters and loads the reset quotas at once; no clearing pass
// a stalled result holds the result register; the stage behind it then holds
// and the input side stalls
//
`default_nettype none

`include "quota_slot_registry_defines.svh"

module quota_slot_registry (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  qsr_pkg::t_in_item           i_in,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output qsr_pkg::t_out_item          o_out,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [qsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [qsr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import qsr_pkg::*;

    // configuration
    logic                r_perimeter_up;
    logic [COUNT_W-1:0]  r_quota [CLASS_LIMIT];

    // registry state
    logic [NUM_SLOTS-1:0] r_slot_valid;
    logic [SIDE_W-1:0]    r_slot_class [NUM_SLOTS];
    logic [COUNT_W-1:0]   r_class_count [N_CLS];
    logic [TOT_W-1:0]     r_total;
    logic                 r_act;

    // stage one: taken item and its slot class read
    logic                 r_s1_vld;
    t_in_item             r_in;
    logic [SIDE_W-1:0]    r_rd_cls;
    logic                 r_fwd_hit;
    logic [SIDE_W-1:0]    r_fwd_cls;

    // result register
    logic                 r_out_vld;
    t_out_item            r_out;

    logic                 in_acc;
    logic                 s1_go;
    logic [SLOT_W-1:0]    s1_idx;
    logic [CLS_W-1:0]     s1_cidx;
    logic                 id_ok;
    logic                 cls_ok;
    logic                 held;
    logic [SIDE_W-1:0]    held_cls;
    logic                 quota_met;
    logic                 wr_en;
    t_status              n_status;
    logic [TOT_W-1:0]     n_total;
    logic                 n_act;
    t_out_item            n_out;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign s1_go       = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_s1_vld && !s1_go;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // configuration writes, unknown indexes are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perimeter_up <= 1'b0;
            for (int k = 0; k < CLASS_LIMIT; k++) begin
                r_quota[k] <= QUOTA_RESET[k];
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index) inside
                CFG_PERIMETER_UP: begin
                    r_perimeter_up <= i_cfg_data[0];
                end
                CFG_QUOTA_SOUTH, CFG_QUOTA_NORTH, CFG_QUOTA_WEST,
                CFG_QUOTA_EAST_LEFT, CFG_QUOTA_EAST_RIGHT, CFG_QUOTA_GATE: begin
                    r_quota[i_cfg_index - CFG_IDX_W'(1)] <= i_cfg_data[COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage one: decide the command against current state
    // ------------------------------------------------------------------
    assign s1_idx    = r_in.slot_id[SLOT_W-1:0];
    assign s1_cidx   = r_in.side[CLS_W-1:0];
    assign id_ok     = r_in.slot_id < SLOTS_ID;
    assign cls_ok    = r_in.side < CLS_LIMIT;
    assign held      = r_slot_valid[s1_idx];
    // class written by the item just ahead is not in the read data yet
    assign held_cls  = r_fwd_hit ? r_fwd_cls : r_rd_cls;
    assign quota_met = r_class_count[s1_cidx] >= r_quota[r_in.side];
    assign n_total   = r_total + TOT_W'(1);

    always_comb begin
        n_status = ST_OK;
        wr_en    = 1'b0;
        if (!r_perimeter_up) begin
            n_status = ST_NOT_INIT;
        end else if (!id_ok) begin
            n_status = ST_BAD_ARG;
        end else if (r_in.command == CMD_QUERY) begin
            n_status = held ? ST_OK : ST_NOT_REG;
        end else if (!cls_ok) begin
            n_status = ST_BAD_ARG;
        end else if (held) begin
            // same class again is a no-op
            n_status = (held_cls == r_in.side) ? ST_OK : ST_DUPLICATE;
        end else if (quota_met) begin
            n_status = ST_FULL;
        end else begin
            wr_en = s1_go;
        end
    end

    assign n_act = r_act || (wr_en && (n_total >= SLOTS_TOT));

    always_comb begin
        n_out.status      = n_status;
        n_out.total_count = wr_en ? OUT_T_W'(n_total) : OUT_T_W'(r_total);
        n_out.all_active  = n_act;
    end

    // ------------------------------------------------------------------
    // slot class memory: read on accept, written by stage one
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_class[s1_idx] <= r_in.side;
        end
        if (in_acc) begin
            r_rd_cls <= r_slot_class[i_in.slot_id[SLOT_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // input register and forward of a same-edge class write
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in      <= i_in;
            r_fwd_hit <= wr_en && (i_in.slot_id == r_in.slot_id);
            r_fwd_cls <= r_in.side;
        end
    end

    // ------------------------------------------------------------------
    // registry state update
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_total      <= '0;
            r_act        <= 1'b0;
            for (int k = 0; k < N_CLS; k++) begin
                r_class_count[k] <= '0;
            end
        end else if (wr_en) begin
            r_slot_valid[s1_idx]    <= 1'b1;
            r_class_count[s1_cidx]  <= r_class_count[s1_cidx] + COUNT_W'(1);
            r_total                 <= n_total;
            r_act                   <= n_act;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `QSR_ASSERT_RST(a_total_bound, i_clk, i_rst_n, r_total <= SLOTS_TOT, "total above slot count")
    `QSR_ASSERT_RST(a_total_step, i_clk, i_rst_n, wr_en |=> (r_total == $past(r_total) + TOT_W'(1)), "total did not step by one")
    `QSR_ASSERT_RST(a_active_full, i_clk, i_rst_n, r_act |-> (r_total == SLOTS_TOT), "active without full registry")
    `QSR_ASSERT_RST(a_fwd_valid, i_clk, i_rst_n, (r_s1_vld && r_fwd_hit) |-> r_slot_valid[s1_idx], "forwarded class for an empty slot")

endmodule

`default_nettype wire
